// ===== hw/rtl/pvwa_pkg.sv =====
// ----------------------------------------------------------------------------
// pvwa_pkg
// shared types, codes and widths of the pitch vote window agents block
// ----------------------------------------------------------------------------
package pvwa_pkg;

    localparam int NUM_AGENTS_DEF = 16;
    localparam int MAX_RESULTS    = 16;
    localparam int NOUT_W         = 5;
    localparam int QW             = 17;

    localparam logic [1:0] OP_AMP   = 2'd0;
    localparam logic [1:0] OP_PITCH = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_STOP  = 2'd3;

    localparam logic CFG_WINDOW  = 1'b0;
    localparam logic CFG_MINPROB = 1'b1;

    localparam logic DIV_PROB = 1'b0;
    localparam logic DIV_MEAN = 1'b1;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_CRD   = 11'b000_0000_0010,
        S_CWR   = 11'b000_0000_0100,
        S_OPEN  = 11'b000_0000_1000,
        S_TRD   = 11'b000_0001_0000,
        S_TEVAL = 11'b000_0010_0000,
        S_PDIV  = 11'b000_0100_0000,
        S_PCHK  = 11'b000_1000_0000,
        S_MDIV  = 11'b001_0000_0000,
        S_PUSH  = 11'b010_0000_0000,
        S_FLUSH = 11'b100_0000_0000
    } t_state;

    typedef struct packed {
        logic [15:0] pitch;
        logic [23:0] hits;
        logic [23:0] seen;
        logic [39:0] sum;
        logic [15:0] tl;
    } t_agent;

    typedef struct packed {
        logic [15:0] pitch;
        logic [15:0] mean;
        logic [16:0] prob;
    } t_res;

    typedef struct packed {
        logic amp_ld;
        logic pitch_ld;
        logic stop;
        logic rd;
        logic cnt_upd;
        logic open;
        logic tk_upd;
        logic div_start;
        logic div_sel;
        logic prob_ld;
        logic mean_ld;
        logic push;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic live;
        logic expire;
        logic div_done;
        logic div_busy;
        logic prob_ok;
        logic can_push;
        logic out_free;
        logic pend_v;
    } t_sts;

endpackage

// ===== hw/rtl/pvwa_div.sv =====
// ----------------------------------------------------------------------------
// pvwa_div
// restoring divider, one quotient bit per cycle, quotient saturates
// ----------------------------------------------------------------------------
module pvwa_div
    import pvwa_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [39:0]   i_dvd,
    input  logic [23:0]   i_dvs,
    output logic          o_busy,
    output logic          o_done,
    output logic [QW-1:0] o_quo
);

    logic          r_busy;
    logic          r_done;
    logic [4:0]    r_cnt;
    logic [23:0]   r_rem;
    logic [QW-1:0] r_low;
    logic [23:0]   r_dvs;
    logic [QW-1:0] r_q;
    logic [24:0]   n_trial;

    assign n_trial = {r_rem, r_low[QW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvs <= i_dvs;
                r_cnt <= '0;
                if (i_dvs == '0) begin
                    r_q    <= '0;
                    r_done <= 1'b1;
                end else if ({1'b0, i_dvd} >= {i_dvs, {QW{1'b0}}}) begin
                    r_q    <= '1;
                    r_done <= 1'b1;
                end else begin
                    r_q    <= '0;
                    r_rem  <= {1'b0, i_dvd[39:QW]};
                    r_low  <= i_dvd[QW-1:0];
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (n_trial >= {1'b0, r_dvs}) begin
                    r_rem <= 24'(n_trial - {1'b0, r_dvs});
                    r_q   <= {r_q[QW-2:0], 1'b1};
                end else begin
                    r_rem <= n_trial[23:0];
                    r_q   <= {r_q[QW-2:0], 1'b0};
                end
                r_low <= {r_low[QW-2:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// ===== hw/rtl/pvwa_dp.sv =====
// ----------------------------------------------------------------------------
// pvwa_dp
// agent store, counting and expiry updates, divider and result registers
// ----------------------------------------------------------------------------
module pvwa_dp
    import pvwa_pkg::*;
#(
    parameter int NUM_AGENTS = NUM_AGENTS_DEF,
    parameter int IW         = $clog2(NUM_AGENTS)
)(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  logic [IW-1:0] i_idx,
    output t_sts          o_sts,
    input  logic [15:0]   i_pitch,
    input  logic [15:0]   i_amplitude,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [16:0]   i_cfg_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [15:0]   o_voted_pitch,
    output logic [15:0]   o_mean_amplitude,
    output logic [16:0]   o_probability,
    output logic          o_last
);

    t_agent              r_mem [NUM_AGENTS];
    t_agent              r_rd;
    logic [NUM_AGENTS-1:0] r_live;
    logic [15:0]         r_window;
    logic [16:0]         r_minprob;
    logic [15:0]         r_held;
    logic [15:0]         r_pin;
    logic [IW-1:0]       r_free;
    logic                r_free_v;
    logic [16:0]         r_prob;
    logic [15:0]         r_mean;
    logic                r_pend_v;
    t_res                r_pend;
    logic                r_out_v;
    t_res                r_out;
    logic                r_last;

    logic                n_we;
    logic [IW-1:0]       n_waddr;
    t_agent              n_wdata;
    logic                n_live;
    logic                n_expire;
    logic [40:0]         n_sum;
    logic [39:0]         n_dvd;
    logic [23:0]         n_dvs;
    logic                w_div_busy;
    logic                w_div_done;
    logic [QW-1:0]       w_quo;
    t_res                n_res;

    assign n_live   = r_live[i_idx];
    assign n_expire = n_live && (r_rd.tl <= 16'd1);
    assign n_sum    = {1'b0, r_rd.sum} + {25'd0, r_held};

    always_comb begin
        n_we    = 1'b0;
        n_waddr = i_idx;
        n_wdata = r_rd;
        if (i_cmd.cnt_upd && n_live) begin
            n_we = 1'b1;
            if (r_rd.seen != '1) begin
                n_wdata.seen = r_rd.seen + 24'd1;
            end
            if (r_rd.pitch == r_pin) begin
                if (r_rd.hits != '1) begin
                    n_wdata.hits = r_rd.hits + 24'd1;
                end
                n_wdata.sum = n_sum[40] ? '1 : n_sum[39:0];
            end
        end else if (i_cmd.open) begin
            n_we    = 1'b1;
            n_waddr = r_free_v ? r_free : '0;
            n_wdata = '{pitch: r_pin, hits: 24'd1, seen: 24'd1,
                        sum: {24'd0, r_held}, tl: r_window};
        end else if (i_cmd.tk_upd && n_live && !n_expire) begin
            n_we       = 1'b1;
            n_wdata.tl = r_rd.tl - 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_waddr] <= n_wdata;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[i_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live    <= '0;
            r_window  <= '0;
            r_minprob <= '0;
            r_held    <= '0;
            r_free_v  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WINDOW:  r_window  <= i_cfg_data[15:0];
                    CFG_MINPROB: r_minprob <= i_cfg_data;
                    default:     r_window  <= r_window;
                endcase
            end
            if (i_cmd.amp_ld) begin
                r_held <= i_amplitude;
            end
            if (i_cmd.pitch_ld) begin
                r_pin    <= i_pitch;
                r_free_v <= 1'b0;
            end
            if (i_cmd.cnt_upd && !n_live && !r_free_v) begin
                r_free   <= i_idx;
                r_free_v <= 1'b1;
            end
            if (i_cmd.stop) begin
                r_live <= '0;
            end else if (i_cmd.open) begin
                r_live[n_waddr] <= 1'b1;
            end else if (i_cmd.tk_upd && n_expire) begin
                r_live[i_idx] <= 1'b0;
            end
        end
    end

    assign n_dvd = (i_cmd.div_sel == DIV_MEAN) ? r_rd.sum : {r_rd.hits, 16'd0};
    assign n_dvs = (i_cmd.div_sel == DIV_MEAN) ? r_rd.hits : r_rd.seen;

    pvwa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_dvd   (n_dvd),
        .i_dvs   (n_dvs),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign n_res = '{pitch: r_rd.pitch, mean: r_mean, prob: r_prob};

    always_ff @(posedge i_clk) begin
        if (i_cmd.prob_ld) begin
            r_prob <= w_quo;
        end
        if (i_cmd.mean_ld) begin
            r_mean <= w_quo[16] ? 16'hFFFF : w_quo[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                if (r_pend_v) begin
                    r_out   <= r_pend;
                    r_last  <= 1'b0;
                    r_out_v <= 1'b1;
                end else if (r_out_v && i_out_ready) begin
                    r_out_v <= 1'b0;
                end
                r_pend   <= n_res;
                r_pend_v <= 1'b1;
            end else if (i_cmd.flush) begin
                r_out    <= r_pend;
                r_last   <= 1'b1;
                r_out_v  <= 1'b1;
                r_pend_v <= 1'b0;
            end else if (r_out_v && i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_sts = '{live: n_live, expire: n_expire, div_done: w_div_done,
                     div_busy: w_div_busy, prob_ok: (r_prob >= r_minprob),
                     can_push: (!r_pend_v || !r_out_v), out_free: !r_out_v,
                     pend_v: r_pend_v};

    assign o_out_valid      = r_out_v;
    assign o_voted_pitch    = r_out.pitch;
    assign o_mean_amplitude = r_out.mean;
    assign o_probability    = r_out.prob;
    assign o_last           = r_last;

endmodule

// ===== hw/rtl/pvwa_ctrl.sv =====
// ----------------------------------------------------------------------------
// pvwa_ctrl
// sequencer: walks the agent slots for pitch counting and for ticks
// ----------------------------------------------------------------------------
module pvwa_ctrl
    import pvwa_pkg::*;
#(
    parameter int NUM_AGENTS = NUM_AGENTS_DEF,
    parameter int IW         = $clog2(NUM_AGENTS)
)(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_op,
    input  t_sts          i_sts,
    output t_cmd          o_cmd,
    output logic [IW-1:0] o_idx
);

    t_state            r_state, n_state;
    logic [IW-1:0]     r_idx, n_idx;
    logic [NOUT_W-1:0] r_nout, n_nout;
    logic              n_acc;
    logic              n_end;

    assign n_acc = i_in_valid && (r_state == S_IDLE);
    assign n_end = (r_idx == IW'(NUM_AGENTS - 1));

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_nout  = r_nout;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (n_acc) begin
                    n_idx = '0;
                    case (i_op)
                        OP_AMP:   o_cmd.amp_ld = 1'b1;
                        OP_PITCH: begin
                            o_cmd.pitch_ld = 1'b1;
                            n_state        = S_CRD;
                        end
                        OP_TICK: begin
                            n_nout  = '0;
                            n_state = S_TRD;
                        end
                        default:  o_cmd.stop = 1'b1;
                    endcase
                end
            end
            S_CRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_CWR;
            end
            S_CWR: begin
                o_cmd.cnt_upd = 1'b1;
                if (n_end) begin
                    n_state = S_OPEN;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_CRD;
                end
            end
            S_OPEN: begin
                o_cmd.open = 1'b1;
                n_state    = S_IDLE;
            end
            S_TRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_TEVAL;
            end
            S_TEVAL: begin
                o_cmd.tk_upd = 1'b1;
                if (i_sts.expire) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_PROB;
                    n_state         = S_PDIV;
                end else if (n_end) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_TRD;
                end
            end
            S_PDIV: begin
                if (i_sts.div_done) begin
                    o_cmd.prob_ld = 1'b1;
                    n_state       = S_PCHK;
                end
            end
            S_PCHK: begin
                if (i_sts.prob_ok && (r_nout < NOUT_W'(MAX_RESULTS))) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_MEAN;
                    n_state         = S_MDIV;
                end else if (n_end) begin
                    n_state = S_FLUSH;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_TRD;
                end
            end
            S_MDIV: begin
                o_cmd.div_sel = DIV_MEAN;
                if (i_sts.div_done) begin
                    o_cmd.mean_ld = 1'b1;
                    n_state       = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_sts.can_push) begin
                    o_cmd.push = 1'b1;
                    n_nout     = r_nout + 1'b1;
                    if (n_end) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_TRD;
                    end
                end
            end
            S_FLUSH: begin
                if (!i_sts.pend_v) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_nout  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_nout  <= n_nout;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_idx      = r_idx;

endmodule

// ===== hw/rtl/pitch_vote_window_agents.sv =====
// ----------------------------------------------------------------------------
// pitch_vote_window_agents
// votes raw pitch estimates over a window of agents, one agent per estimate
// ----------------------------------------------------------------------------
// Transactions are handled one at a time. An amplitude update or a stop is
// done in the idle state. For a pitch estimate every agent slot is read from
// the agent store and written back in turn, then the new agent is opened. A
// tick walks every slot too, adding a probability division for each expiring
// agent and a mean amplitude division for each agent that emits, both on one
// shared bit-serial divider, and it may wait for the result register to be
// taken. Results leave through a one-deep holding stage and an output
// register, so the final transaction of a tick is known and flagged with
// o_last.
module pitch_vote_window_agents
    import pvwa_pkg::*;
#(
    parameter int NUM_AGENTS = NUM_AGENTS_DEF
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_pitch,
    input  logic [15:0] i_amplitude,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_voted_pitch,
    output logic [15:0] o_mean_amplitude,
    output logic [16:0] o_probability,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [16:0] i_cfg_data
);

    localparam int IW = $clog2(NUM_AGENTS);

    t_cmd          w_cmd;
    t_sts          w_sts;
    logic [IW-1:0] w_idx;

    pvwa_ctrl #(
        .NUM_AGENTS (NUM_AGENTS),
        .IW         (IW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_op),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    pvwa_dp #(
        .NUM_AGENTS (NUM_AGENTS),
        .IW         (IW)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_idx            (w_idx),
        .o_sts            (w_sts),
        .i_pitch          (i_pitch),
        .i_amplitude      (i_amplitude),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_voted_pitch    (o_voted_pitch),
        .o_mean_amplitude (o_mean_amplitude),
        .o_probability    (o_probability),
        .o_last           (o_last)
    );

`ifndef SYNTHESIS
    a_prob_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_probability <= 17'd65536))
        else $error("probability above one");

    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_sts.div_busy)
        else $error("divider busy while taking transactions");

    a_idle_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> !w_sts.pend_v)
        else $error("held result left over after tick");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the pitch vote window agents block: a queue-fed
// driver with bursty valid, a monitor with its own stall pattern, and a
// behavioral agent model that predicts every voted result field by field
// ----------------------------------------------------------------------------
module tb_top;
    import pvwa_pkg::*;

    localparam int AGENTS  = 16;
    localparam logic [23:0] CNT_TOP = 24'hFFFFFF;
    localparam logic [39:0] SUM_TOP = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] pitch;
        logic [15:0] amp;
    } t_item;

    typedef struct packed {
        logic [15:0] pitch;
        logic [15:0] mean;
        logic [16:0] prob;
        logic        last;
    } t_vote;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_op;
    logic [15:0] i_pitch;
    logic [15:0] i_amplitude;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [15:0] o_voted_pitch;
    logic [15:0] o_mean_amplitude;
    logic [16:0] o_probability;
    logic        o_last;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [16:0] i_cfg_data;

    pitch_vote_window_agents u_dut (.*);

    // agent model state
    logic        ag_live [AGENTS];
    logic [15:0] ag_pitch [AGENTS];
    logic [23:0] ag_hits [AGENTS];
    logic [23:0] ag_seen [AGENTS];
    logic [39:0] ag_sum [AGENTS];
    logic [15:0] ag_left [AGENTS];
    logic [15:0] held_amp;
    logic [15:0] win_ticks;
    logic [16:0] min_prob;

    t_item pending_items[$];
    t_vote expected_votes[$];
    int    n_fail;
    int    n_sent;
    int    n_votes;
    int    n_ticks;
    bit    hold_off;
    bit    stim_done;

    function automatic logic [23:0] sat_inc(logic [23:0] v);
        return (v == CNT_TOP) ? v : v + 24'd1;
    endfunction

    task automatic model_reset();
        for (int i = 0; i < AGENTS; i++) begin
            ag_live[i] = 0; ag_pitch[i] = 0; ag_hits[i] = 0;
            ag_seen[i] = 0; ag_sum[i] = 0; ag_left[i] = 0;
        end
        held_amp = 0; win_ticks = 0; min_prob = 0;
    endtask

    task automatic predict_votes(t_item it);
        int slot;
        int n;
        logic [40:0] s;
        logic [63:0] p;
        logic [63:0] m;
        t_vote v;
        case (it.op)
            OP_AMP: held_amp = it.amp;
            OP_PITCH: begin
                for (int i = 0; i < AGENTS; i++) begin
                    if (ag_live[i]) begin
                        ag_seen[i] = sat_inc(ag_seen[i]);
                        if (ag_pitch[i] == it.pitch) begin
                            ag_hits[i] = sat_inc(ag_hits[i]);
                            s = {1'b0, ag_sum[i]} + held_amp;
                            ag_sum[i] = s[40] ? SUM_TOP : s[39:0];
                        end
                    end
                end
                slot = 0;
                while (slot < AGENTS && ag_live[slot]) slot++;
                if (slot >= AGENTS) slot = 0;
                ag_live[slot] = 1; ag_pitch[slot] = it.pitch;
                ag_hits[slot] = 1; ag_seen[slot] = 1;
                ag_sum[slot] = held_amp; ag_left[slot] = win_ticks;
            end
            OP_TICK: begin
                n = 0;
                for (int i = 0; i < AGENTS; i++) begin
                    if (!ag_live[i]) continue;
                    if (ag_left[i] > 1) begin
                        ag_left[i]--;
                        continue;
                    end
                    ag_live[i] = 0; ag_left[i] = 0;
                    p = (ag_seen[i] != 0) ? ({40'd0, ag_hits[i]} << 16) / ag_seen[i] : 0;
                    if (p > 65536) p = 65536;
                    if (p < min_prob || n >= MAX_RESULTS) continue;
                    m = (ag_hits[i] != 0) ? {24'd0, ag_sum[i]} / ag_hits[i] : 0;
                    if (m > 16'hFFFF) m = 16'hFFFF;
                    v.pitch = ag_pitch[i]; v.mean = m[15:0];
                    v.prob = p[16:0]; v.last = 0;
                    expected_votes.push_back(v);
                    n++;
                end
                if (n > 0) expected_votes[$].last = 1;
            end
            default: begin
                for (int i = 0; i < AGENTS; i++) begin
                    ag_live[i] = 0; ag_left[i] = 0;
                end
            end
        endcase
    endtask

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // driver: bursts of random length with random gaps
    int burst_left;
    int gap_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (i_in_valid && !o_in_ready) begin
            // hold the transaction until taken
        end else begin
            if (i_in_valid) begin
                predict_votes(pending_items.pop_front());
                n_sent++;
            end
            if (gap_left > 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 0;
            end else if (pending_items.size() > 0) begin
                i_in_valid  <= 1;
                i_op        <= pending_items[0].op;
                i_pitch     <= pending_items[0].pitch;
                i_amplitude <= pending_items[0].amp;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(12, 1);
                    gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(60, 1);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_in_valid <= 0;
            end
        end
    end

    // monitor with its own stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_votes++;
                if (expected_votes.size() == 0) begin
                    $display("%0t: unexpected transaction pitch %h", $time, o_voted_pitch);
                    n_fail++;
                end else begin
                    t_vote e;
                    e = expected_votes.pop_front();
                    if (e.pitch !== o_voted_pitch) begin
                        $display("%0t: pitch exp %h got %h", $time, e.pitch, o_voted_pitch);
                        n_fail++;
                    end
                    if (e.mean !== o_mean_amplitude) begin
                        $display("%0t: mean exp %h got %h", $time, e.mean, o_mean_amplitude);
                        n_fail++;
                    end
                    if (e.prob !== o_probability) begin
                        $display("%0t: prob exp %h got %h", $time, e.prob, o_probability);
                        n_fail++;
                    end
                    if (e.last !== o_last) begin
                        $display("%0t: last exp %b got %b", $time, e.last, o_last);
                        n_fail++;
                    end
                end
            end
            i_out_ready <= hold_off ? 1'b0 : (($time / 70) % 4 != 0) || ($urandom_range(1, 0) == 1);
        end
    end

    // long receiver hold-off counted in cycles
    initial begin
        hold_off = 0;
        wait (n_sent > 60);
        hold_off = 1;
        repeat (2000) @(posedge i_clk);
        hold_off = 0;
    end

    task automatic add_item(logic [1:0] op, logic [15:0] p, logic [15:0] a);
        t_item it;
        it.op = op; it.pitch = p; it.amp = a;
        pending_items.push_back(it);
        if (op == OP_TICK) n_ticks++;
    endtask

    task automatic cfg_write(logic idx, logic [16:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == CFG_WINDOW) win_ticks = val[15:0];
        else min_prob = val;
    endtask

    task automatic drain();
        wait (pending_items.size() == 0 && !i_in_valid);
        wait (expected_votes.size() == 0);
        repeat (1200) @(posedge i_clk);
    endtask

    task automatic add_phrase();
        logic [15:0] base;
        int len;
        base = $urandom_range(3, 0) == 0 ? 16'($urandom) : 16'($urandom_range(4, 0));
        len = $urandom_range(6, 1);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(2, 0) == 0) add_item(OP_AMP, 16'($urandom), 16'($urandom));
            add_item(OP_PITCH, $urandom_range(1, 0) ? base : base + 16'($urandom_range(2, 0)),
                     16'($urandom));
        end
        add_item(OP_TICK, 16'($urandom), 16'($urandom));
    endtask

    task automatic add_random(int n);
        for (int k = 0; k < n; k++) begin
            int r;
            r = $urandom_range(99, 0);
            if (r < 75) add_phrase();
            else if (r < 85) add_item(OP_STOP, 16'($urandom), 16'($urandom));
            else if (r < 95) add_item(OP_TICK, 16'($urandom), 16'($urandom));
            else add_item(OP_AMP, 16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        logic [16:0] th;
        n_fail = 0; n_sent = 0; n_votes = 0; n_ticks = 0; stim_done = 0;
        i_rst_n = 0; i_op = 0; i_pitch = 0; i_amplitude = 0;
        i_cfg_we = 0; i_cfg_idx = 0; i_cfg_data = 0; i_in_valid = 0;
        model_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, all ops, all slots busy, guards
        cfg_write(CFG_WINDOW, 0);
        cfg_write(CFG_MINPROB, 0);
        add_item(OP_TICK, 0, 0);
        add_item(OP_AMP, 16'hFFFF, 16'hFFFF);
        add_item(OP_PITCH, 16'hFFFF, 0);
        add_item(OP_PITCH, 16'hFFFF, 0);
        add_item(OP_AMP, 0, 0);
        add_item(OP_PITCH, 0, 16'hFFFF);
        add_item(OP_TICK, 0, 0);
        for (int k = 0; k < 17; k++) add_item(OP_PITCH, 16'(k % 3), 0);
        add_item(OP_TICK, 0, 0);
        add_item(OP_STOP, 16'hFFFF, 16'hFFFF);
        drain();

        cfg_write(CFG_WINDOW, 16'hFFFF);
        cfg_write(CFG_MINPROB, 17'h10000);
        add_item(OP_PITCH, 16'h1234, 16'h5678);
        add_item(OP_PITCH, 16'h1234, 0);
        add_item(OP_TICK, 0, 0);
        add_item(OP_STOP, 0, 0);
        add_item(OP_TICK, 0, 0);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            cfg_write(CFG_WINDOW, 16'($urandom_range(ph == 5 ? 4 : 3, 0)));
            case (ph)
                0: th = 0;
                1: th = 17'h10000;
                2: th = 17'h1FFFF;
                default: th = 17'($urandom_range(65536, 0));
            endcase
            cfg_write(CFG_MINPROB, th);
            add_random(7);
            drain();
        end
        stim_done = 1;
        $display("sent %0d transactions with %0d ticks, checked %0d voted results",
                 n_sent, n_ticks, n_votes);
        if (n_fail == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
